/* sv/sid_pkg.sv */
package sid_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned TOTAL_W       = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_PUSH   = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_READ   = 3'd4,
    OP_COUNT  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_ADD_HEAD,
    MODE_ADD_TAIL,
    MODE_ADD_SORT,
    MODE_POP
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       cmp_signed;
  } cell_ctrl_t;

endpackage

/* sv/sid_cell.sv */
module sid_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                      clk_i,
  input  sid_pkg::cell_ctrl_t       ctrl_i,
  input  logic [sid_pkg::WORD_W-1:0] word_i,
  input  logic [CNT_W-1:0]          cnt_i,
  input  logic [sid_pkg::WORD_W-1:0] left_data_i,
  input  logic [sid_pkg::WORD_W-1:0] right_data_i,
  input  logic                      found_i,
  output logic                      found_o,
  output logic [sid_pkg::WORD_W-1:0] data_o
);
  import sid_pkg::*;

  logic [WORD_W-1:0] data_q, data_d;
  logic              valid;
  logic              greater;
  logic              mark;

  assign valid   = CNT_W'(IDX) < cnt_i;
  assign greater = {data_q[WORD_W-1] ^ ctrl_i.cmp_signed, data_q[WORD_W-2:0]} >
                   {word_i[WORD_W-1] ^ ctrl_i.cmp_signed, word_i[WORD_W-2:0]};

  always_comb begin
    unique case (ctrl_i.mode)
      MODE_ADD_HEAD: mark = 1'b1;
      MODE_ADD_TAIL: mark = !valid;
      MODE_ADD_SORT: mark = !valid || greater;
      default:       mark = 1'b0;
    endcase
  end

  assign found_o = found_i | mark;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.mode) inside
      MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_ADD_SORT: begin
        if (found_i) begin
          data_d = left_data_i;
        end else if (mark) begin
          data_d = word_i;
        end
      end
      MODE_POP: data_d = right_data_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* sv/sorted_insert_deque.sv */
// Sorted insert deque: a bounded ordered store of 32-bit words held in a
// row of cells, one word per cell, position 0 at the head.
// Command channel: drive operation_i, entry_data_i and position_i with
// start_i; a command transfers at a rising edge with start_i high and
// busy_o low. busy_o stays low, so a command may transfer every cycle.
// Operations: append at tail, push at head, pop head, sorted insert,
// read a position, read the count.
// Result channel: the cycle after each command transfer, done_o is high
// for exactly one cycle with read_data_o, status_o and entry_total_o.
// Throughput is one command per cycle; every cell shifts, loads or holds
// at the transfer edge, on an add as the insert-point flag ripples along
// the cells. The receiver cannot stall: done_o marks a result for one
// cycle only. compare_signed is written through cfg_we_i and cfg_data_i;
// the user does so only while idle, which the block does not enforce.
// Reset clears the count, done_o and compare_signed; stored words are
// undefined until written and are never read before.
module sorted_insert_deque #(
  parameter int unsigned DEPTH = sid_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [sid_pkg::OP_W-1:0]     operation_i,
  input  logic [sid_pkg::WORD_W-1:0]   entry_data_i,
  input  logic [sid_pkg::POS_W-1:0]    position_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_data_i,
  output logic                         done_o,
  output logic [sid_pkg::WORD_W-1:0]   read_data_o,
  output logic [sid_pkg::STATUS_W-1:0] status_o,
  output logic [sid_pkg::TOTAL_W-1:0]  entry_total_o
);
  import sid_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cmp_signed_q;
  logic              done_q;
  logic [WORD_W-1:0] rdata_q, rdata_d;
  status_e           status_q, status_d;
  logic [TOTAL_W-1:0] total_q;

  logic              xfer;
  logic              full;
  logic              empty;
  logic              pos_ok;
  logic [WORD_W-1:0] pos_data;
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH:0]    found;

  assign busy_o = 1'b0;
  assign xfer   = start_i && !busy_o;
  assign full   = cnt_q == CNT_W'(DEPTH);
  assign empty  = cnt_q == '0;
  assign pos_ok = (32'(position_i) < 32'(cnt_q)) && (32'(position_i) < DEPTH);

  always_comb begin
    pos_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(position_i) == i) begin
        pos_data = cell_data[i];
      end
    end
  end

  always_comb begin
    ctrl.cmp_signed = cmp_signed_q;
    ctrl.mode       = MODE_HOLD;
    cnt_d           = cnt_q;
    rdata_d         = '0;
    status_d        = ST_OK;
    if (xfer) begin
      unique case (operation_i) inside
        OP_APPEND, OP_PUSH, OP_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (operation_i == OP_APPEND) begin
              ctrl.mode = MODE_ADD_TAIL;
            end else if (operation_i == OP_PUSH) begin
              ctrl.mode = MODE_ADD_HEAD;
            end else begin
              ctrl.mode = MODE_ADD_SORT;
            end
          end
        end
        OP_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.mode = MODE_POP;
            cnt_d     = cnt_q - 1'b1;
            rdata_d   = cell_data[0];
          end
        end
        OP_READ: begin
          if (pos_ok) begin
            rdata_d = pos_data;
          end else begin
            status_d = ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_data;
    logic [WORD_W-1:0] right_data;

    if (g == 0) begin : g_head
      assign left_data = entry_data_i;
    end else begin : g_mid
      assign left_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_data = entry_data_i;
    end else begin : g_inner
      assign right_data = cell_data[g+1];
    end

    sid_cell #(
      .IDX  (g),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .word_i      (entry_data_i),
      .cnt_i       (cnt_q),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .found_i     (found[g]),
      .found_o     (found[g+1]),
      .data_o      (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      cmp_signed_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= xfer;
      if (cfg_we_i) begin
        cmp_signed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      rdata_q  <= rdata_d;
      status_q <= status_d;
      total_q  <= TOTAL_W'(cnt_d);
    end
  end

  assign done_o        = done_q;
  assign read_data_o   = rdata_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("count above depth");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> done_o)
    else $error("result strobe missing");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && operation_i == OP_POP && empty |=> status_o == ST_EMPTY && read_data_o == '0)
    else $error("pop from empty store misreported");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !full && (operation_i == OP_APPEND || operation_i == OP_PUSH ||
    operation_i == OP_INSERT) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("add did not advance count");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && full && (operation_i == OP_APPEND || operation_i == OP_PUSH ||
    operation_i == OP_INSERT) |=> status_o == ST_FULL && $stable(cnt_q))
    else $error("add to full store not dropped");

endmodule
